// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the list engine.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off during reset, with a fixed message.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");

// Clocked assertion, held off during reset, with a caller message.
`define CHK_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== src/ual_pkg.sv =====
// Shared types and constants of the unordered list engine.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package ual_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int OP_W    = 4;
	localparam int ITEM_W  = 32;
	localparam int POS_W   = 7;
	localparam int STAT_W  = 2;
	localparam int FOUND_W = 6;
	localparam int COUNT_W = 7;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 48;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND    = 4'd0,
		OP_DEL_AT    = 4'd1,
		OP_DEL_VAL   = 4'd2,
		OP_SEARCH    = 4'd3,
		OP_INSERT_AT = 4'd4,
		OP_DEL_LAST  = 4'd5,
		OP_GET_LAST  = 4'd6,
		OP_CLEAR     = 4'd7,
		OP_DEDUP     = 4'd8
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// read address source
	typedef enum logic [1:0] {
		RA_SCAN = 2'd0,
		RA_LAST = 2'd1,
		RA_POS  = 2'd2,
		RA_GAP  = 2'd3
	} rd_sel_t;

	// write address source
	typedef enum logic [1:0] {
		WA_FILL = 2'd0,
		WA_POS  = 2'd1,
		WA_GAP  = 2'd2
	} wr_sel_t;

	typedef enum logic [1:0] {
		FILL_HOLD = 2'd0,
		FILL_INC  = 2'd1,
		FILL_DEC  = 2'd2,
		FILL_CLR  = 2'd3
	} fill_op_t;

	typedef enum logic [2:0] {
		GAP_HOLD      = 3'd0,
		GAP_POS       = 3'd1,
		GAP_HIT       = 3'd2,
		GAP_AFTER_HIT = 3'd3,
		GAP_INC       = 3'd4
	} gap_op_t;

	typedef struct packed {
		logic     load;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     wr_data_rd;
		fill_op_t fill_op;
		gap_op_t  gap_op;
		logic     scan_clr;
		logic     scan_inc;
		logic     set_status;
		status_t  status_code;
		logic     set_found;
		logic     set_last;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic del_pos_bad;
		logic ins_pos_bad;
		logic scan_more;
		logic chk_v;
		logic match;
		logic gap_in_list;
		logic out_free;
	} dp_status_t;

endpackage

// ===== src/ual_dp.sv =====
// Datapath of the list engine: entry memory, fill count, scan and gap
// indexes, result fields and output register. Depends on ual_pkg.
`timescale 1ns / 1ps

module ual_dp #(
	parameter int CAPACITY = ual_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ual_pkg::IN_W-1:0] s_tdata,
	input  ual_pkg::cmd_t            cmd,
	output ual_pkg::dp_status_t      st,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [ual_pkg::OUT_W-1:0] m_tdata
);
	import ual_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [ITEM_W-1:0] mem_q [CAPACITY];
	logic [ITEM_W-1:0] rd_data_q;
	logic [ITEM_W-1:0] item_q;
	logic [POS_W-1:0]  pos_q;
	op_t               op_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  gap_q;
	logic              chk_v_s1;
	logic [CNT_W-1:0]  chk_idx_s1;
	status_t           status_q;
	logic [FOUND_W-1:0] found_q;
	logic [ITEM_W-1:0] last_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  fill_ext;
	logic [CMP_W-1:0]  pos_m1;
	logic [CNT_W-1:0]  fill_m1;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [ITEM_W-1:0] wr_data;

	assign pos_ext  = CMP_W'(pos_q);
	assign fill_ext = CMP_W'(fill_q);
	assign pos_m1   = pos_ext - CMP_W'(1);
	assign fill_m1  = fill_q - CNT_W'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			RA_SCAN: rd_addr = scan_q[IDX_W-1:0];
			RA_LAST: rd_addr = fill_m1[IDX_W-1:0];
			RA_POS:  rd_addr = pos_m1[IDX_W-1:0];
			RA_GAP:  rd_addr = gap_q[IDX_W-1:0];
			default: rd_addr = scan_q[IDX_W-1:0];
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WA_FILL: wr_addr = fill_q[IDX_W-1:0];
			WA_POS:  wr_addr = pos_m1[IDX_W-1:0];
			WA_GAP:  wr_addr = gap_q[IDX_W-1:0];
			default: wr_addr = gap_q[IDX_W-1:0];
		endcase
	end

	assign wr_data = cmd.wr_data_rd ? rd_data_q : item_q;

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// captured input item and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(s_tdata[OP_W-1:0]);
			item_q <= s_tdata[OP_W +: ITEM_W];
			pos_q  <= s_tdata[OP_W+ITEM_W +: POS_W];
		end
		if (cmd.load) begin
			status_q <= ST_OK;
			found_q  <= '0;
			last_q   <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.set_found) begin
				found_q <= FOUND_W'(chk_idx_s1);
			end
			if (cmd.set_last) begin
				last_q <= rd_data_q;
			end
		end
		if (cmd.out_load) begin
			m_tdata_q <= {1'b0, COUNT_W'(fill_q), last_q, found_q, status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			scan_q     <= '0;
			gap_q      <= '0;
			chk_v_s1   <= 1'b0;
			chk_idx_s1 <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (cmd.fill_op)
				FILL_INC: fill_q <= fill_q + CNT_W'(1);
				FILL_DEC: fill_q <= fill_m1;
				FILL_CLR: fill_q <= '0;
				default:  fill_q <= fill_q;
			endcase
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			unique case (cmd.gap_op)
				GAP_POS:       gap_q <= pos_ext[CNT_W-1:0];
				GAP_HIT:       gap_q <= chk_idx_s1;
				GAP_AFTER_HIT: gap_q <= chk_idx_s1 + CNT_W'(1);
				GAP_INC:       gap_q <= gap_q + CNT_W'(1);
				default:       gap_q <= gap_q;
			endcase
			chk_v_s1   <= cmd.rd_en && (cmd.rd_sel == RA_SCAN);
			chk_idx_s1 <= scan_q;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign st.op          = op_q;
	assign st.empty       = (fill_q == '0);
	assign st.full        = (fill_q >= CNT_W'(CAPACITY));
	assign st.del_pos_bad = (pos_ext >= fill_ext);
	assign st.ins_pos_bad = (pos_q == '0) || (pos_ext > fill_ext);
	assign st.scan_more   = (scan_q < fill_q);
	assign st.chk_v       = chk_v_s1;
	assign st.match       = (rd_data_q == item_q);
	assign st.gap_in_list = (gap_q < fill_q);
	assign st.out_free    = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== src/ual_ctrl.sv =====
// Sequencing state machine of the list engine: decodes each operation and
// drives the datapath commands. Depends on ual_pkg.
`timescale 1ns / 1ps

module ual_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  ual_pkg::dp_status_t st,
	output ual_pkg::cmd_t       cmd
);
	import ual_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_DECODE  = 11'b000_0000_0010,
		S_SCAN    = 11'b000_0000_0100,
		S_MOVE    = 11'b000_0000_1000,
		S_INS_OLD = 11'b000_0001_0000,
		S_INS_NEW = 11'b000_0010_0000,
		S_GETL    = 11'b000_0100_0000,
		S_DUP_RD  = 11'b000_1000_0000,
		S_DUP_CHK = 11'b001_0000_0000,
		S_DUP_MV  = 11'b010_0000_0000,
		S_FINISH  = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.rd_sel  = RA_SCAN;
		cmd.wr_sel  = WA_FILL;
		cmd.fill_op = FILL_HOLD;
		cmd.gap_op  = GAP_HOLD;
		cmd.status_code = ST_OK;
		state_d     = state_q;

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				unique case (st.op)
					OP_APPEND: begin
						if (st.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WA_FILL;
							cmd.fill_op = FILL_INC;
						end
					end
					OP_DEL_AT: begin
						if (st.del_pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_BAD;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_LAST;
							cmd.gap_op = GAP_POS;
							state_d    = S_MOVE;
						end
					end
					OP_DEL_VAL, OP_SEARCH, OP_DEDUP: begin
						cmd.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end
					OP_INSERT_AT: begin
						if (st.ins_pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_BAD;
						end else if (st.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_FULL;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS;
							state_d    = S_INS_OLD;
						end
					end
					OP_DEL_LAST: begin
						if (st.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
						end else begin
							cmd.fill_op = FILL_DEC;
						end
					end
					OP_GET_LAST: begin
						if (st.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_LAST;
							state_d    = S_GETL;
						end
					end
					OP_CLEAR: begin
						cmd.fill_op = FILL_CLR;
					end
					default: begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_BAD;
					end
				endcase
			end
			S_SCAN: begin
				// one read issued per cycle, checked in the next cycle
				if (st.chk_v && st.match) begin
					unique case (st.op)
						OP_SEARCH: begin
							cmd.set_found = 1'b1;
							state_d       = S_FINISH;
						end
						OP_DEL_VAL: begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_LAST;
							cmd.gap_op = GAP_HIT;
							state_d    = S_MOVE;
						end
						default: begin
							cmd.gap_op = GAP_AFTER_HIT;
							state_d    = S_DUP_RD;
						end
					endcase
				end else if (st.scan_more) begin
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RA_SCAN;
					cmd.scan_inc = 1'b1;
				end else if (!st.chk_v) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_BAD;
					state_d         = S_FINISH;
				end
			end
			S_MOVE: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WA_GAP;
				cmd.wr_data_rd = 1'b1;
				cmd.fill_op    = FILL_DEC;
				state_d        = S_FINISH;
			end
			S_INS_OLD: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WA_FILL;
				cmd.wr_data_rd = 1'b1;
				cmd.fill_op    = FILL_INC;
				state_d        = S_INS_NEW;
			end
			S_INS_NEW: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WA_POS;
				state_d    = S_FINISH;
			end
			S_GETL: begin
				cmd.set_last = 1'b1;
				state_d      = S_FINISH;
			end
			S_DUP_RD: begin
				if (st.gap_in_list) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_GAP;
					state_d    = S_DUP_CHK;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DUP_CHK: begin
				if (st.match) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_LAST;
					state_d    = S_DUP_MV;
				end else begin
					cmd.gap_op = GAP_INC;
					state_d    = S_DUP_RD;
				end
			end
			S_DUP_MV: begin
				// the moved entry lands in the gap and is checked again
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = WA_GAP;
				cmd.wr_data_rd = 1'b1;
				cmd.fill_op    = FILL_DEC;
				state_d        = S_DUP_RD;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/unordered_array_list_engine.sv =====
// Top level of the unordered list engine: controller plus datapath.
// Depends on ual_pkg, ual_ctrl and ual_dp.
`timescale 1ns / 1ps

// Usage
// - Slave channel s_*: one operation per transfer. s_tdata packs, from bit 0:
//   op (4), item (32, signed), position (7), then zero fill to 48 bits.
// - Master channel m_*: exactly one result per operation, in order.
//   m_tdata packs, from bit 0: status (2), found_index (6),
//   last_value (32, signed), entry_count (7), then one zero bit.
// - Each operation is decoded, then ends in a finish state that loads the
//   result once the output register is free. Delete at and get last read
//   the last entry first; insert at writes the old entry to the end, then
//   the item at its position. Search and delete by value read one entry per
//   cycle over the entry memory's single read port. Remove duplicates checks
//   each later entry in turn and swaps the last entry into each match.
// - One operation is in work at a time; s_tready is high only between
//   operations, so a new transfer lands only after the previous operation
//   has finished, and a finished result waits in the output register while
//   the next operation is accepted.
// - If the receiver stalls m_tready, the result holds in the output
//   register and the engine waits before publishing the next result.
// - Reset empties the list at once (fill count to zero); no memory sweep
//   is needed since only slots below the count are ever read.
module unordered_array_list_engine #(
	parameter int CAPACITY = ual_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ual_pkg::IN_W-1:0]  s_tdata,  // op, item, position
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ual_pkg::OUT_W-1:0] m_tdata   // status, found_index, last_value, entry_count
);
	import ual_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	// sequencer: decodes the operation and steps scans and moves
	ual_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// memory, counters, result fields and output register
	ual_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== src/ual_chk.sv =====
// Port-level checker for the list engine, bound to the top level.
// Depends on ual_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ual_chk #(
	parameter int CAPACITY = ual_pkg::CAPACITY_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [ual_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ual_pkg::OUT_W-1:0] m_tdata
);
	import ual_pkg::*;

	logic in_xfer;
	logic fail_res;
	logic cap_small;

	assign in_xfer   = s_tvalid && s_tready && (s_tdata[IN_W-1] == 1'b0);
	assign fail_res  = m_tvalid && (m_tdata[1:0] != ST_OK);
	assign cap_small = (CAPACITY < 128);

	// stalled result holds
	`CHK_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// one operation in work at a time
	`CHK_ASSERT_MSG(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "accepted a second operation while busy")

	// a failed operation reports no index and no value
	`CHK_ASSERT_MSG(a_fail_clean, clk, arst_n, fail_res |-> (m_tdata[7:2] == '0) && (m_tdata[39:8] == '0), "failed result carries data")

	// empty status comes with a zero count; count never passes capacity (capacity below 128)
	`CHK_ASSERT(a_count_range, clk, arst_n, m_tvalid && cap_small && in_xfer == in_xfer |-> ((m_tdata[1:0] != ST_EMPTY) || (m_tdata[46:40] == '0)) && (int'(m_tdata[46:40]) <= CAPACITY))

endmodule

bind unordered_array_list_engine ual_chk #(.CAPACITY(CAPACITY)) u_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking bench for the unordered list engine: directed corner cases, then a
// mostly well-formed random mix, with input gaps and output stalls.
// Depends on ual_pkg and unordered_array_list_engine.
`timescale 1ns / 1ps

module tb_top;
	import ual_pkg::*;

	localparam int TOTAL_OPS   = 575;
	localparam int LONG_HOLD   = 400;
	localparam int HOLD_AFTER  = 150;
	localparam int TAIL_OPS    = 60;
	localparam int DRAIN_WAIT  = 300;
	localparam int OP_CODE_TOP = (1 << OP_W) - 1;
	localparam int MODE_GROW   = 0;
	localparam int MODE_CHURN  = 1;
	localparam int MODE_SHRINK = 2;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [ITEM_W-1:0] item;
		logic [POS_W-1:0]         pos;
	} list_cmd_t;

	typedef struct packed {
		status_t                  status;
		logic [FOUND_W-1:0]       found;
		logic signed [ITEM_W-1:0] last;
		logic [COUNT_W-1:0]       count;
	} list_result_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	// shadow of the list contents and fill count
	logic [ITEM_W-1:0]   model_slot [CAPACITY_DEF];
	int                  model_count;
	logic [ITEM_W-1:0]   value_pool [8];

	list_cmd_t           op_backlog [$];
	list_result_t        awaited_results [$];
	list_cmd_t           op_in_flight;

	int                  gap_left;
	int                  stall_left;
	int                  drained;
	logic                long_hold_done;
	logic                calm_tail;
	int                  mismatch_count;
	int                  results_checked;
	int                  full_seen;
	int                  empty_seen;
	int                  op_tally [16];

	unordered_array_list_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// first slot holding v, or -1
	function automatic int list_find(logic [ITEM_W-1:0] v);
		for (int i = 0; i < model_count; i++)
			if (model_slot[i] == v)
				return i;
		return -1;
	endfunction

	// move the last entry into the gap and shrink
	function automatic void close_gap(int idx);
		model_slot[idx] = model_slot[model_count - 1];
		model_count--;
	endfunction

	// apply one operation to the shadow list and return the reply it should give
	function automatic list_result_t list_apply(list_cmd_t c);
		list_result_t r;
		int hit;
		int j;
		logic [ITEM_W-1:0] moved;
		r.status = ST_OK;
		r.found  = '0;
		r.last   = '0;
		case (c.op)
			OP_APPEND: begin
				if (model_count >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					model_slot[model_count] = c.item;
					model_count++;
				end
			end
			OP_DEL_AT: begin
				if (c.pos >= model_count)
					r.status = ST_BAD;
				else
					close_gap(int'(c.pos));
			end
			OP_DEL_VAL: begin
				hit = list_find(c.item);
				if (hit < 0)
					r.status = ST_BAD;
				else
					close_gap(hit);
			end
			OP_SEARCH: begin
				hit = list_find(c.item);
				if (hit < 0)
					r.status = ST_BAD;
				else
					r.found = hit[FOUND_W-1:0];
			end
			OP_INSERT_AT: begin
				// bad position wins over a full list
				if (c.pos == 0 || c.pos > model_count) begin
					r.status = ST_BAD;
				end else if (model_count >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					moved = model_slot[c.pos - 1];
					model_slot[c.pos - 1] = c.item;
					model_slot[model_count] = moved;
					model_count++;
				end
			end
			OP_DEL_LAST: begin
				if (model_count == 0)
					r.status = ST_EMPTY;
				else
					model_count--;
			end
			OP_GET_LAST: begin
				if (model_count == 0)
					r.status = ST_EMPTY;
				else
					r.last = model_slot[model_count - 1];
			end
			OP_CLEAR: model_count = 0;
			OP_DEDUP: begin
				hit = list_find(c.item);
				if (hit < 0) begin
					r.status = ST_BAD;
				end else begin
					// an entry swapped into the gap must be checked again
					j = hit + 1;
					while (j < model_count) begin
						if (model_slot[j] == c.item)
							close_gap(j);
						else
							j++;
					end
				end
			end
			default: r.status = ST_BAD;
		endcase
		r.count = model_count[COUNT_W-1:0];
		return r;
	endfunction

	// queue an operation and track its effect so later picks see the list
	task automatic push_op(int op, logic [ITEM_W-1:0] item, logic [POS_W-1:0] pos);
		list_cmd_t c;
		c.op   = op[OP_W-1:0];
		c.item = item;
		c.pos  = pos;
		void'(list_apply(c));
		op_backlog.push_back(c);
	endtask

	function automatic logic [ITEM_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return value_pool[$urandom_range(0, 7)];
		if (roll < 80 && model_count > 0)
			return model_slot[$urandom_range(0, model_count - 1)];
		return $urandom;
	endfunction

	// weights are listed in op code order; the last one covers the unused codes
	function automatic int pick_op(int mode);
		int w [10];
		int roll;
		int acc;
		case (mode)
			MODE_GROW:  w = '{45, 5, 5, 10, 15, 3, 6, 1, 7, 3};
			MODE_CHURN: w = '{25, 10, 10, 15, 10, 8, 8, 2, 9, 3};
			default:    w = '{10, 18, 15, 12, 5, 15, 6, 3, 13, 3};
		endcase
		roll = $urandom_range(0, 99);
		acc = 0;
		for (int k = 0; k <= OP_DEDUP; k++) begin
			acc += w[k];
			if (roll < acc)
				return k;
		end
		return $urandom_range(OP_DEDUP + 1, OP_CODE_TOP);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Sender: predict at each transfer, then offer the next operation or idle.
	always @(posedge clk or negedge arst_n) begin : drive_ops
		list_cmd_t nxt;
		list_result_t want;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			gap_left  <= 0;
			calm_tail <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				want = list_apply(op_in_flight);
				awaited_results.push_back(want);
				op_tally[op_in_flight.op]++;
				if (want.status == ST_FULL)
					full_seen++;
				if (want.status == ST_EMPTY)
					empty_seen++;
			end
			calm_tail <= (op_backlog.size() < TAIL_OPS);
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (s_tvalid && !calm_tail && $urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(0, 9);
					s_tvalid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					nxt = op_backlog.pop_front();
					op_in_flight <= nxt;
					s_tdata  <= {{(IN_W - OP_W - ITEM_W - POS_W){1'b0}}, nxt.pos, nxt.item, nxt.op};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random short stalls, plus one long hold to back the engine up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready       <= 1'b0;
			stall_left     <= 0;
			drained        <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				drained <= drained + 1;
			if (!long_hold_done && drained >= HOLD_AFTER) begin
				long_hold_done <= 1'b1;
				stall_left     <= LONG_HOLD - 1;
				m_tready       <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 9);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				$error("result with no operation outstanding: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
				check_field("found_index", 32'(want.found), 32'(m_tdata[7:2]));
				check_field("last_value", want.last, m_tdata[39:8]);
				check_field("entry_count", 32'(want.count), 32'(m_tdata[46:40]));
				results_checked++;
			end
		end
	end

	initial begin : run_list
		int mode;
		int code;
		int since_mode;
		logic [ITEM_W-1:0] v;
		logic [POS_W-1:0] p;
		logic filled_once;

		value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
			$urandom, $urandom, $urandom, $urandom};
		model_count = 0;
		filled_once = 1'b0;

		// empty-list corners
		push_op(OP_GET_LAST, 32'h1234_5678, 7'd0);
		push_op(OP_DEL_LAST, 32'h0, 7'd0);
		push_op(OP_SEARCH, 32'h5, 7'd0);
		push_op(OP_DEL_AT, 32'h0, 7'd0);
		push_op(OP_DEDUP, 32'h7, 7'd0);
		// value extremes, one duplicated
		push_op(OP_APPEND, 32'h8000_0000, 7'd0);
		push_op(OP_APPEND, 32'h7FFF_FFFF, 7'd0);
		push_op(OP_APPEND, 32'h0, 7'd0);
		push_op(OP_APPEND, 32'hFFFF_FFFF, 7'd0);
		push_op(OP_APPEND, 32'h7FFF_FFFF, 7'd127);
		push_op(OP_SEARCH, 32'h7FFF_FFFF, 7'd0);
		push_op(OP_GET_LAST, 32'h0, 7'd0);
		// insert at: position zero, past the end, then a good one
		push_op(OP_INSERT_AT, 32'hA5A5_A5A5, 7'd0);
		push_op(OP_INSERT_AT, 32'hA5A5_A5A5, 7'd6);
		push_op(OP_INSERT_AT, 32'h7FFF_FFFF, 7'd1);
		// dedup with two later copies of the value
		push_op(OP_DEDUP, 32'h7FFF_FFFF, 7'd0);
		push_op(OP_DEL_VAL, 32'h0, 7'd0);
		push_op(OP_DEL_VAL, 32'h0001_2345, 7'd0);
		push_op(OP_DEL_AT, 32'h0, 7'd1);
		push_op(OP_DEL_AT, 32'h0, 7'd127);
		push_op(OP_DEDUP + 1, 32'hFFFF_FFFF, 7'd127);
		push_op(OP_CODE_TOP, 32'hFFFF_FFFF, 7'd127);
		push_op(OP_DEL_LAST, 32'h0, 7'd0);
		push_op(OP_CLEAR, 32'h0, 7'd0);
		push_op(OP_GET_LAST, 32'h0, 7'd0);

		mode = MODE_GROW;
		since_mode = 0;
		while (op_backlog.size() < TOTAL_OPS) begin
			if (since_mode == 40) begin
				mode = $urandom_range(MODE_GROW, MODE_SHRINK);
				since_mode = 0;
			end
			since_mode++;
			// once, fill to capacity and poke the full list
			if (!filled_once && op_backlog.size() >= 220) begin
				filled_once = 1'b1;
				while (model_count < CAPACITY_DEF - 1)
					push_op(OP_APPEND, pick_value(), POS_W'($urandom_range(0, 127)));
				v = $urandom;
				push_op(OP_APPEND, v, 7'd0);
				push_op(OP_APPEND, pick_value(), 7'd0);
				push_op(OP_INSERT_AT, pick_value(), POS_W'($urandom_range(1, CAPACITY_DEF)));
				push_op(OP_SEARCH, v, 7'd0);
				push_op(OP_GET_LAST, 32'h0, 7'd0);
				push_op(OP_DEDUP, value_pool[$urandom_range(0, 7)], 7'd0);
				mode = MODE_SHRINK;
				since_mode = 0;
			end
			code = pick_op(mode);
			v = pick_value();
			p = POS_W'($urandom_range(0, 127));
			if (code == OP_DEL_AT && model_count > 0 && $urandom_range(0, 4) != 0)
				p = POS_W'($urandom_range(0, model_count - 1));
			if (code == OP_INSERT_AT && model_count > 0 && $urandom_range(0, 4) != 0)
				p = POS_W'($urandom_range(1, model_count));
			push_op(code, v, p);
		end
		// the sender replays the queue against a fresh list
		model_count = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d list operations: %0d appends, %0d inserts, %0d dedups, %0d unused codes",
			results_checked, op_tally[OP_APPEND], op_tally[OP_INSERT_AT], op_tally[OP_DEDUP],
			op_tally[9] + op_tally[10] + op_tally[11] + op_tally[12] + op_tally[13]
			+ op_tally[14] + op_tally[15]);
		$display("Full-list replies %0d, empty-list replies %0d, mismatches %0d",
			full_seen, empty_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d results still awaited", awaited_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/ual_pkg.sv
src/ual_dp.sv
src/ual_ctrl.sv
src/unordered_array_list_engine.sv
src/ual_chk.sv
tb/tb_top.sv
